// ===== rtl/mrg_pkg.sv =====
// Package for the mount rotation block: widths, constants, register indexes.
// No dependencies.
package mrg_pkg;
    localparam int ACCEL_WIDTH_DEF = 16;
    localparam int ROW_W = 16;
    localparam int TOL_W = 13;
    localparam int SINE_W = 15;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] REG_ACCEL_TOL = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_SINE = 1'd1;
    localparam int ONE_G_Q12 = 4096;
    localparam int ONE_Q14 = 16384;
    localparam logic [TOL_W-1:0] TOL_RESET = 13'd410;
    localparam logic [SINE_W-1:0] SINE_RESET = 15'd2841;
endpackage

// ===== rtl/mrg_if.sv =====
// Valid/ready channel interfaces for the mount rotation block.
// Depends on mrg_pkg.
interface mrg_in_if import mrg_pkg::*; #(parameter int AW = ACCEL_WIDTH_DEF) ();
    logic valid;
    logic ready;
    logic signed [AW-1:0] accel_x;
    logic signed [AW-1:0] accel_y;
    logic signed [AW-1:0] accel_z;
    logic [2:0] forward_axis;
    modport source (output valid, accel_x, accel_y, accel_z, forward_axis, input ready);
    modport sink (input valid, accel_x, accel_y, accel_z, forward_axis, output ready);
endinterface

interface mrg_out_if import mrg_pkg::*; ();
    logic valid;
    logic ready;
    logic ok;
    logic calibrated;
    logic signed [ROW_W-1:0] fwd_x, fwd_y, fwd_z;
    logic signed [ROW_W-1:0] right_x, right_y, right_z;
    logic signed [ROW_W-1:0] down_x, down_y, down_z;
    modport source (output valid, ok, calibrated, fwd_x, fwd_y, fwd_z, right_x, right_y,
                    right_z, down_x, down_y, down_z, input ready);
    modport sink (input valid, ok, calibrated, fwd_x, fwd_y, fwd_z, right_x, right_y,
                  right_z, down_x, down_y, down_z, output ready);
endinterface

interface mrg_cfg_if import mrg_pkg::*; ();
    logic valid;
    logic ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_DATA_W-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/mount_rotation_from_gravity.sv =====
// Mount rotation from gravity: top level, sequencer and shared arithmetic units.
// Depends on mrg_pkg and the channel interfaces in mrg_if.sv.
//
// Usage: write accel_tolerance (index 0) and min_forward_sine (index 1) on the
// config channel while idle. Send one resting sample with a forward axis code
// on the input channel; one result comes back on the output channel with the
// ok bit, the calibrated flag and the stored rotation rows (Q1.14).
// A sample whose magnitude is out of tolerance or whose projection is too short
// skips the remaining steps. Two square roots run one result bit per cycle,
// six rounding divisions each take a load, 50 restoring steps and a sign fix,
// and one shared 33x33 multiplier handles every product, one per cycle. The
// block accepts one sample at a time; ready is low while a sample is in work
// and while its result waits.
// Reset clears the matrix to zero, clears the calibrated flag and loads the
// register defaults. If the receiver stalls, the result holds on the output
// until taken; the next sample is accepted from the cycle after it leaves.
module mount_rotation_from_gravity import mrg_pkg::*; #(
    parameter int ACCEL_WIDTH = ACCEL_WIDTH_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    mrg_in_if.sink   i_in,
    mrg_out_if.source o_out,
    mrg_cfg_if.sink  i_cfg
);
    localparam int AW = ACCEL_WIDTH;
    localparam logic [3:0] S_IDLE = 4'd0, S_MUL = 4'd1, S_SQRT = 4'd2, S_CHK = 4'd3,
        S_DIV = 4'd4, S_PROJ = 4'd5, S_LIM = 4'd6, S_CROSS = 4'd7, S_DONE = 4'd8,
        S_OUT = 4'd9;

    logic [3:0] r_st;
    logic [TOL_W-1:0] r_tol;
    logic [SINE_W-1:0] r_sine;
    logic signed [ROW_W-1:0] r_rows [9];
    logic r_cal, r_ok, r_pass;
    logic signed [AW-1:0] r_a [3];
    logic [1:0] r_k;
    logic r_s;
    logic [4:0] r_step;
    logic [5:0] r_cnt;
    logic signed [63:0] r_acc;
    logic [63:0] r_rem, r_rad, r_root;
    logic [31:0] r_den;
    logic signed [31:0] r_nr [3];
    logic signed [ROW_W-1:0] r_dn [3], r_fw [3], r_rt [3];
    logic r_fwd_phase;

    assign i_cfg.ready = 1'b1;
    assign i_in.ready = (r_st == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol <= TOL_RESET;
            r_sine <= SINE_RESET;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                REG_ACCEL_TOL: r_tol <= i_cfg.data[TOL_W-1:0];
                REG_MIN_SINE: r_sine <= i_cfg.data[SINE_W-1:0];
                default: ;
            endcase
        end
    end

    // projection square index (steps 3..5 read r_nr[0..2])
    logic [1:0] pj_idx;
    assign pj_idx = 2'(r_step - 5'd3);

    // shared multiplier operands
    logic signed [32:0] mul_a, mul_b;
    logic signed [65:0] mul_p;
    assign mul_p = mul_a * mul_b;

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (r_st)
            S_MUL: begin
                mul_a = 33'(r_a[r_step[1:0]]);
                mul_b = 33'(r_a[r_step[1:0]]);
            end
            S_PROJ: begin
                if (r_step < 5'd3) begin
                    mul_a = 33'(r_dn[r_step[1:0]]);
                    mul_b = 33'(r_dn[r_k]);
                end else begin
                    mul_a = 33'(r_nr[pj_idx]);
                    mul_b = 33'(r_nr[pj_idx]);
                end
            end
            S_LIM: begin
                mul_a = 33'(r_sine);
                mul_b = 33'(r_sine);
            end
            S_CROSS: begin
                unique case (r_step[2:0])
                    3'd0: begin mul_a = 33'(r_dn[1]); mul_b = 33'(r_fw[2]); end
                    3'd1: begin mul_a = 33'(r_dn[2]); mul_b = 33'(r_fw[1]); end
                    3'd2: begin mul_a = 33'(r_dn[2]); mul_b = 33'(r_fw[0]); end
                    3'd3: begin mul_a = 33'(r_dn[0]); mul_b = 33'(r_fw[2]); end
                    3'd4: begin mul_a = 33'(r_dn[0]); mul_b = 33'(r_fw[1]); end
                    default: begin mul_a = 33'(r_dn[1]); mul_b = 33'(r_fw[0]); end
                endcase
            end
            default: ;
        endcase
    end

    // sqrt step (one result bit a cycle)
    logic [63:0] sq_bit, sq_try;
    assign sq_bit = 64'd1 << {r_cnt[4:0], 1'b0};
    assign sq_try = r_root + sq_bit;

    // narrowing of the cross product accumulator
    logic [63:0] cr_mag;
    logic [49:0] cr_q;
    logic signed [ROW_W-1:0] cr_res;
    assign cr_mag = r_acc[63] ? 64'(-r_acc) : 64'(r_acc);
    assign cr_q = 50'((cr_mag + 64'd8192) >> 14);
    always_comb begin
        logic [ROW_W-1:0] q;
        q = (cr_q > 50'(ONE_Q14)) ? ROW_W'(ONE_Q14) : cr_q[ROW_W-1:0];
        cr_res = r_acc[63] ? -$signed(q) : $signed(q);
    end

    // projection floor: min_forward_sine^2 in Q2.28 squared units (valid in S_LIM)
    logic [63:0] lim;
    assign lim = 64'(mul_p) << 28;

    // divider bookkeeping: r_rem holds partial remainder, r_rad holds quotient
    logic [4:0] dv_idx;
    assign dv_idx = r_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE;
            r_cal <= 1'b0;
            for (int i = 0; i < 9; i++) r_rows[i] <= '0;
        end else begin
            unique case (r_st)
                S_IDLE: if (i_in.valid) begin
                    r_a[0] <= i_in.accel_x;
                    r_a[1] <= i_in.accel_y;
                    r_a[2] <= i_in.accel_z;
                    r_k <= (i_in.forward_axis <= 3'd5) ? i_in.forward_axis[2:1] : 2'd0;
                    r_s <= (i_in.forward_axis <= 3'd5) && i_in.forward_axis[0];
                    r_step <= '0;
                    r_acc <= '0;
                    r_st <= S_MUL;
                end
                S_MUL: begin
                    r_acc <= r_acc + 64'(mul_p);
                    if (r_step == 5'd2) begin
                        r_rad <= 64'(r_acc + 64'(mul_p));
                        r_root <= '0;
                        r_cnt <= 6'd31;
                        r_fwd_phase <= 1'b0;
                        r_st <= S_SQRT;
                    end
                    r_step <= r_step + 5'd1;
                end
                S_SQRT: begin
                    if (r_rad >= sq_try) begin
                        r_rad <= r_rad - sq_try;
                        r_root <= (r_root >> 1) + sq_bit;
                    end else begin
                        r_root <= r_root >> 1;
                    end
                    r_cnt <= r_cnt - 6'd1;
                    if (r_cnt == 6'd0) r_st <= S_CHK;
                end
                S_CHK: begin
                    r_step <= '0;
                    r_cnt <= '0;
                    if (!r_fwd_phase) begin
                        if (r_root == 64'd0 ||
                            (r_root > 64'(ONE_G_Q12) ?
                             r_root - 64'(ONE_G_Q12) : 64'(ONE_G_Q12) - r_root)
                            > 64'(r_tol)) begin
                            r_pass <= 1'b0;
                            r_st <= S_DONE;
                        end else begin
                            r_den <= r_root[31:0];
                            r_st <= S_DIV;
                        end
                    end else begin
                        r_den <= r_root[31:0];
                        r_st <= S_DIV;
                    end
                end
                S_DIV: begin
                    // cnt 0 loads numerator; then 50 bit steps of restoring division
                    if (r_cnt == 6'd0) begin
                        logic [63:0] nm;
                        nm = r_fwd_phase ?
                            64'(r_nr[dv_idx[1:0]][31] ? -r_nr[dv_idx[1:0]] : r_nr[dv_idx[1:0]])
                          : 64'(r_a[dv_idx[1:0]][AW-1] ? -64'(r_a[dv_idx[1:0]])
                                                      : 64'(r_a[dv_idx[1:0]]));
                        r_root <= (nm << 15) + 64'(r_den);
                        r_rem <= '0;
                        r_rad <= '0;
                        r_cnt <= 6'd1;
                    end else if (r_cnt <= 6'd50) begin
                        logic [64:0] t;
                        t = {r_rem, r_root[49]};
                        r_root <= r_root << 1;
                        if (t >= {32'd0, r_den, 1'b0}) begin
                            r_rem <= 64'(t - {32'd0, r_den, 1'b0});
                            r_rad <= {r_rad[62:0], 1'b1};
                        end else begin
                            r_rem <= t[63:0];
                            r_rad <= {r_rad[62:0], 1'b0};
                        end
                        r_cnt <= r_cnt + 6'd1;
                    end else begin
                        logic neg;
                        logic signed [ROW_W-1:0] q;
                        neg = r_fwd_phase ? r_nr[dv_idx[1:0]][31] : !r_a[dv_idx[1:0]][AW-1];
                        neg = neg && (r_fwd_phase ? 1'b1 : (r_a[dv_idx[1:0]] != '0));
                        q = neg ? -$signed(r_rad[ROW_W-1:0]) : $signed(r_rad[ROW_W-1:0]);
                        if (r_fwd_phase) r_fw[dv_idx[1:0]] <= q;
                        else r_dn[dv_idx[1:0]] <= q;
                        r_cnt <= '0;
                        if (r_step == 5'd2) begin
                            r_step <= '0;
                            r_acc <= '0;
                            r_st <= r_fwd_phase ? S_CROSS : S_PROJ;
                        end else begin
                            r_step <= r_step + 5'd1;
                        end
                    end
                end
                S_PROJ: begin
                    // steps 0..2 build r_nr, steps 3..5 accumulate squares
                    if (r_step < 5'd3) begin
                        logic signed [31:0] p, v;
                        p = 32'(mul_p);
                        v = -p + ((r_step[1:0] == r_k) ? 32'sd268435456 : 32'sd0);
                        r_nr[r_step[1:0]] <= r_s ? -v : v;
                        r_step <= r_step + 5'd1;
                    end else begin
                        r_step <= r_step + 5'd1;
                        r_acc <= r_acc + 64'(mul_p);
                        if (r_step == 5'd5) r_st <= S_LIM;
                    end
                end
                S_LIM: begin
                    if (r_acc == 64'sd0 || 64'(r_acc) < lim) begin
                        r_pass <= 1'b0;
                        r_st <= S_DONE;
                    end else begin
                        r_rad <= 64'(r_acc);
                        r_root <= '0;
                        r_cnt <= 6'd31;
                        r_fwd_phase <= 1'b1;
                        r_st <= S_SQRT;
                    end
                end
                S_CROSS: begin
                    if (!r_step[0]) r_acc <= 64'(mul_p);
                    else begin
                        r_acc <= r_acc - 64'(mul_p);
                    end
                    r_step <= r_step + 5'd1;
                    if (r_step == 5'd2 || r_step == 5'd4 || r_step == 5'd6)
                        r_rt[r_step[2:1] - 2'd1] <= cr_res;
                    if (r_step == 5'd6) begin
                        r_pass <= 1'b1;
                        r_st <= S_DONE;
                    end
                end
                S_DONE: begin
                    r_ok <= r_pass;
                    if (r_pass) begin
                        r_cal <= 1'b1;
                        for (int i = 0; i < 3; i++) begin
                            r_rows[i] <= r_fw[i];
                            r_rows[3+i] <= r_rt[i];
                            r_rows[6+i] <= r_dn[i];
                        end
                    end
                    r_st <= S_OUT;
                end
                S_OUT: if (o_out.ready) r_st <= S_IDLE;
                default: r_st <= S_IDLE;
            endcase
        end
    end

    assign o_out.valid = (r_st == S_OUT);
    assign o_out.ok = r_ok;
    assign o_out.calibrated = r_cal;
    assign o_out.fwd_x = r_rows[0];
    assign o_out.fwd_y = r_rows[1];
    assign o_out.fwd_z = r_rows[2];
    assign o_out.right_x = r_rows[3];
    assign o_out.right_y = r_rows[4];
    assign o_out.right_z = r_rows[5];
    assign o_out.down_x = r_rows[6];
    assign o_out.down_y = r_rows[7];
    assign o_out.down_z = r_rows[8];
endmodule

// ===== rtl/mrg_checker.sv =====
// Port-level checker for mount_rotation_from_gravity, bound to the top level.
// Depends on mrg_pkg and the channel interfaces.
module mrg_checker import mrg_pkg::*; (
    input logic i_clk,
    input logic i_rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready,
    input logic out_ok,
    input logic out_cal
);
    // no new sample while a result waits
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid |-> !in_ready) else $error("ready during result");
    // an accepted sample keeps the block busy for the next cycle
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_valid && in_ready) |=> !in_ready) else $error("ready right after accept");
    // a taken result is not repeated: output goes back idle
    a_ret: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_valid && out_ready) |=> !out_valid) else $error("result repeated");
    // ok implies calibrated
    a_okcal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_valid && out_ok) |-> out_cal) else $error("ok without calibrated");
    // calibrated never falls outside reset
    a_calst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(out_cal) && $past(i_rst_n) |-> out_cal) else $error("calibrated dropped");
endmodule

bind mount_rotation_from_gravity mrg_checker u_mrg_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .in_valid(i_in.valid), .in_ready(i_in.ready),
    .out_valid(o_out.valid), .out_ready(o_out.ready),
    .out_ok(o_out.ok), .out_cal(o_out.calibrated)
);
